>>> hdl/pprc_pkg.sv
// Shared widths, item types and operation codes of the path partition run counter.
package pprc_pkg;

  localparam int PATH_W  = 3;
  localparam int RANK_W  = 24;
  localparam int SIDX_W  = 24;
  localparam int PAY_W   = 32;
  localparam int OFS_W   = 24;
  localparam int CNT_W   = 24;

  localparam int PATH_SPAN     = 2 ** PATH_W;
  localparam int NUM_PATHS_DEF = 8;
  localparam int ADDR_BITS_DEF = 24;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_ELEM = 1'b1;

  typedef enum logic [1:0] {
    OP_NULL,
    OP_INIT,
    OP_HOLD,
    OP_WRITE
  } op_kind_e;

  typedef struct packed {
    logic              cmd;
    logic [PATH_W-1:0] path;
    logic              path_active;
    logic [RANK_W-1:0] rank;
    logic [SIDX_W-1:0] sample_index;
    logic [PAY_W-1:0]  payload;
    logic [OFS_W-1:0]  base_offset;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic              write_valid;
    logic [OFS_W-1:0]  dest_index;
    logic [RANK_W-1:0] out_rank;
    logic [SIDX_W-1:0] out_sample_index;
    logic [PAY_W-1:0]  out_payload;
    logic [CNT_W-1:0]  run_count;
    logic              done_res;
  } out_item_t;

  typedef struct packed {
    op_kind_e          kind;
    logic [PATH_W-1:0] path;
    logic [RANK_W-1:0] rank;
    logic [SIDX_W-1:0] sample_index;
    logic [PAY_W-1:0]  payload;
    logic [OFS_W-1:0]  base_offset;
    logic              last;
  } op_t;

endpackage

>>> hdl/pprc_stream_if.sv
// Valid/ready stream interface that carries one item per transfer.
interface pprc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pprc_front.sv
// Front end: accepts input items and classifies them into queue operations.
module pprc_front import pprc_pkg::*; #(
  parameter int NumPaths = NUM_PATHS_DEF
) (
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  input  logic     q_ready_i,
  output logic     push_o,
  output op_t      op_o
);

  logic in_range;

  assign ready_o  = q_ready_i;
  assign push_o   = valid_i && q_ready_i;
  assign in_range = 32'(item_i.path) < 32'(NumPaths);

  always_comb begin
    op_o.path         = item_i.path;
    op_o.rank         = item_i.rank;
    op_o.sample_index = item_i.sample_index;
    op_o.payload      = item_i.payload;
    op_o.base_offset  = item_i.base_offset;
    op_o.last         = item_i.last;
    if (!in_range) begin
      op_o.kind = OP_NULL;
    end else if (item_i.cmd == CMD_INIT) begin
      op_o.kind = OP_INIT;
    end else if (!item_i.path_active) begin
      op_o.kind = OP_HOLD;
    end else begin
      op_o.kind = OP_WRITE;
    end
  end

endmodule

>>> hdl/pprc_fifo.sv
// Small synchronous queue of operations between the front and back ends.
module pprc_fifo import pprc_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o = count_q != CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/pprc_back.sv
// Back end: per-path tables, run counting and the registered result stage.
module pprc_back import pprc_pkg::*; #(
  parameter int NumPaths = NUM_PATHS_DEF,
  parameter int AddrBits = ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Only paths reachable through the path field need an entry.
  localparam int TableDepth = (NumPaths < PATH_SPAN) ? NumPaths : PATH_SPAN;
  localparam int IdxW       = $clog2(TableDepth);

  logic [AddrBits-1:0] offset_q [TableDepth];
  logic [RANK_W-1:0]   prev_q   [TableDepth];
  logic [CNT_W-1:0]    cnt_q    [TableDepth];

  logic                out_valid_q;
  out_item_t           out_item_q;

  logic [IdxW-1:0]     idx;
  logic [AddrBits-1:0] cur_offset;
  logic [RANK_W-1:0]   cur_prev;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic                do_init;
  logic                do_write;
  out_item_t           res;

  assign pop_o       = op_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign idx        = IdxW'(op_i.path);
  assign cur_offset = offset_q[idx];
  assign cur_prev   = prev_q[idx];
  assign cur_cnt    = cnt_q[idx];
  assign new_cnt    = (op_i.rank != cur_prev) ? cur_cnt + CNT_W'(1) : cur_cnt;

  always_comb begin
    res          = '0;
    res.done_res = op_i.last;
    do_init      = 1'b0;
    do_write     = 1'b0;
    unique case (op_i.kind)
      OP_INIT: begin
        do_init = pop_o;
      end
      OP_HOLD: begin
        res.run_count = cur_cnt;
      end
      OP_WRITE: begin
        do_write             = pop_o;
        res.write_valid      = 1'b1;
        res.dest_index       = OFS_W'(cur_offset);
        res.out_rank         = op_i.rank;
        res.out_sample_index = op_i.sample_index;
        res.out_payload      = op_i.payload;
        res.run_count        = new_cnt;
      end
      OP_NULL: begin
        res.run_count = '0;
      end
      default: begin
        res.run_count = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) begin
        cnt_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (do_init) begin
        cnt_q[idx] <= '0;
      end else if (do_write) begin
        cnt_q[idx] <= new_cnt;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_init) begin
      offset_q[idx] <= AddrBits'(op_i.base_offset);
      prev_q[idx]   <= op_i.rank;
    end else if (do_write) begin
      offset_q[idx] <= cur_offset + AddrBits'(1);
      prev_q[idx]   <= op_i.rank;
    end
    if (pop_o) begin
      out_item_q <= res;
    end
  end

endmodule

>>> hdl/path_partition_rank_run_counter_core.sv
// A result is held in the queue and then in the result register before it is offered.
// Throughput: one item per cycle unless the output stalls; the per-path tables
// are flip-flops read and updated in the same cycle, so consecutive items on
// one path need no stall. Reset: queue, result stage and run counts clear at once;
// offsets and previous ranks hold no value until an init command writes them.
module path_partition_rank_run_counter_core import pprc_pkg::*; #(
  parameter int NumPaths = NUM_PATHS_DEF,
  parameter int AddrBits = ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pprc_stream_if.sink          in_i,
  pprc_stream_if.source        out_o
);

  // The front end decodes each incoming transfer into an init, a write, a
  // count report or an empty result, and pushes that operation into a short
  // queue. The back end drains the queue at one operation per cycle while its
  // result register is free or being emptied, so a stalled output backs up
  // into the queue before the input sees ready drop.

  logic q_ready;
  logic q_push;
  op_t  q_wdata;
  logic q_valid;
  logic q_pop;
  op_t  q_rdata;

  pprc_front #(
    .NumPaths (NumPaths)
  ) u_front (
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .item_i    (in_i.data),
    .q_ready_i (q_ready),
    .push_o    (q_push),
    .op_o      (q_wdata)
  );

  // Two entries are enough to keep full rate: the back end pops in the same
  // cycle as a push whenever the output moves.
  pprc_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // The back end owns the per-path offset, previous-rank and count tables and
  // registers every result before it is offered downstream.
  pprc_back #(
    .NumPaths (NumPaths),
    .AddrBits (AddrBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.data)
  );

endmodule
